// ===== rtl/uqpd_pkg.sv =====
`default_nettype none

package uqpd_pkg;

  // sizing of the decoder
  localparam int KEY_BYTES   = 8;
  localparam int OUT_LIMIT   = 1024;
  localparam int VALUE_LIMIT = 1024;

  // register and field widths
  localparam int CHAR_W     = 8;
  localparam int KEY_W      = 64;
  localparam int KLEN_W     = 4;
  localparam int CAP_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam int KEY_REG_BYTES = KEY_W / CHAR_W;
  localparam int KIDX_W        = $clog2(KEY_REG_BYTES);

  // per-url counters
  localparam int ECNT_W = $clog2(OUT_LIMIT);
  localparam int VCNT_W = $clog2(VALUE_LIMIT);

  // command queue between parser and output sequencer
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int MAX_RES = 3;
  localparam int NRES_W  = $clog2(MAX_RES + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = 2'd2;

  // characters
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
  localparam logic [CHAR_W-1:0] CH_QMARK = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;
  localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // one queued command: up to three results, the last may be the status
  typedef struct packed {
    logic [MAX_RES-1:0][CHAR_W-1:0] bytes;
    logic [NRES_W-1:0]              nres;
    logic                           status;
    logic                           found;
  } uqpd_cmd_t;

  function automatic logic is_hex(input logic [CHAR_W-1:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [CHAR_W-1:0] c);
    logic [3:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else begin
      v = 4'(c[3:0] + 4'd9);
    end
    return v;
  endfunction

  // re-creates the hex digit as it arrived
  function automatic logic [CHAR_W-1:0] held_char(input logic [3:0] d, input logic up);
    logic [CHAR_W-1:0] r;
    if (d < 4'd10) begin
      r = 8'(8'h30 + {4'h0, d});
    end else if (up) begin
      r = 8'(8'h37 + {4'h0, d});
    end else begin
      r = 8'(8'h57 + {4'h0, d});
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/uqpd_in_if.sv =====
`default_nettype none

interface uqpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] url_byte;
  logic       end_of_url;

  modport source (output valid, url_byte, end_of_url, input ready);
  modport sink (input valid, url_byte, end_of_url, output ready);
endinterface

`default_nettype wire

// ===== rtl/uqpd_out_if.sv =====
`default_nettype none

interface uqpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       found;
  logic       done_res;

  modport source (output valid, out_char, found, done_res, input ready);
  modport sink (input valid, out_char, found, done_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/url_query_param_decoder.sv =====
// URL query parameter decoder. Takes one URL byte per input beat (end_of_url
// marks the terminator beat), skips everything up to the first '?', splits
// the query on '&' and compares each name with key_bytes/key_length. The value
// of the first matching segment is percent-decoded ('+' to space, %XX to one
// byte, a broken escape passes through literally) and each decoded byte leaves
// as one result beat, up to out_capacity-1 per URL; every URL closes with one
// status beat (done_res=1, found=key matched and out_capacity>=2). An input
// beat can be accepted every cycle unless the command queue is full. A beat
// makes zero to three results, which leave one per cycle unless the output
// stalls; a four-entry command queue between the parser and the output
// sequencer absorbs bursts, and in_ready drops only when that queue is full.
// Results pass through the queue, current-command and output registers.
// Registers are written through the cfg_ port and should change only while
// no URL is in flight; there is no clearing pass after reset.
`default_nettype none

module url_query_param_decoder (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  uqpd_in_if.sink                               in_chan,
  uqpd_out_if.source                            out_chan,
  input  wire logic                             cfg_we,
  input  wire logic [uqpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [uqpd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import uqpd_pkg::*;

  // configuration registers
  logic [KEY_W-1:0]  key_bytes_r;
  logic [KLEN_W-1:0] key_length_r;
  logic [CAP_W-1:0]  out_capacity_r;

  // queue hookup
  uqpd_cmd_t q_cmd;
  uqpd_cmd_t head_cmd;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bytes_r    <= '0;
      key_length_r   <= '0;
      out_capacity_r <= CAP_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_BYTES:    key_bytes_r    <= cfg_wdata[KEY_W-1:0];
        CFG_KEY_LENGTH:   key_length_r   <= cfg_wdata[KLEN_W-1:0];
        CFG_OUT_CAPACITY: out_capacity_r <= cfg_wdata[CAP_W-1:0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // parser: key match, escape decode, buffer limit, at most one command per beat
  uqpd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .key_bytes    (key_bytes_r),
    .key_length   (key_length_r),
    .out_capacity (out_capacity_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  // decouples parser from output stalls
  uqpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // sequencer: spreads each command over result beats
  uqpd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (head_cmd),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  // a command is never offered to a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  // the sequencer never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  // status beats carry no character
  a_status_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.done_res) |-> (out_chan.out_char == '0))
    else $error("status beat with nonzero character");

  // found only rides on status beats
  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.done_res) |-> !out_chan.found)
    else $error("found set on data beat");

endmodule

`default_nettype wire

// ===== rtl/uqpd_front.sv =====
`default_nettype none

module uqpd_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  uqpd_in_if.sink                           in_chan,
  input  wire logic [uqpd_pkg::KEY_W-1:0]   key_bytes,
  input  wire logic [uqpd_pkg::KLEN_W-1:0]  key_length,
  input  wire logic [uqpd_pkg::CAP_W-1:0]   out_capacity,
  input  wire logic                         q_full,
  output logic                              q_push,
  output uqpd_pkg::uqpd_cmd_t               q_cmd
);
  import uqpd_pkg::*;

  localparam logic [2:0] PH_BEFORE_Q = 3'd0;
  localparam logic [2:0] PH_NAME     = 3'd1;
  localparam logic [2:0] PH_SKIP     = 3'd2;
  localparam logic [2:0] PH_VALUE    = 3'd3;
  localparam logic [2:0] PH_DONE     = 3'd4;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HEX  = 2'd2;

  logic [2:0]        phase_r, phase_nxt;
  logic [KLEN_W-1:0] kpos_r, kpos_nxt;
  logic              kmis_r, kmis_nxt;
  logic [1:0]        esc_r, esc_nxt;
  logic [3:0]        hexd_r, hexd_nxt;
  logic              hexup_r, hexup_nxt;
  logic [ECNT_W-1:0] ecnt_r, ecnt_nxt;
  logic [VCNT_W-1:0] vcnt_r, vcnt_nxt;

  logic                           accept;
  logic [CHAR_W-1:0]              c;
  logic [KLEN_W-1:0]              klen_eff;
  logic [CHAR_W-1:0]              kchar;
  logic [CAP_W-1:0]               cap_eff;
  logic                           cap_ok;
  logic [CAP_W-1:0]               limit;
  logic [CAP_W-1:0]               ecnt_ext;
  logic [MAX_RES-1:0][CHAR_W-1:0] rb;
  logic [NRES_W-1:0]              rn;
  logic [NRES_W-1:0]              keep;
  logic                           c_hex;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign c             = in_chan.url_byte;
  assign c_hex         = is_hex(c);

  assign klen_eff = (key_length > KLEN_W'(KEY_BYTES)) ? KLEN_W'(KEY_BYTES) : key_length;
  assign kchar    = (kpos_r < KLEN_W'(KEY_REG_BYTES)) ?
                    key_bytes[{kpos_r[KIDX_W-1:0], 3'b000} +: CHAR_W] : '0;

  assign cap_eff  = (out_capacity > CAP_W'(OUT_LIMIT)) ? CAP_W'(OUT_LIMIT) : out_capacity;
  assign cap_ok   = cap_eff >= CAP_W'(2);
  assign limit    = cap_eff - CAP_W'(1);
  assign ecnt_ext = CAP_W'(ecnt_r);

  // parse step: state update plus the raw list of decoded bytes
  always_comb begin
    phase_nxt = phase_r;
    kpos_nxt  = kpos_r;
    kmis_nxt  = kmis_r;
    esc_nxt   = esc_r;
    hexd_nxt  = hexd_r;
    hexup_nxt = hexup_r;
    vcnt_nxt  = vcnt_r;
    rb        = '0;
    rn        = '0;

    if (in_chan.end_of_url) begin
      if (phase_r == PH_VALUE) begin
        if (esc_r != ESC_NONE) begin
          rb[rn] = CH_PCT;
          rn     = rn + NRES_W'(1);
        end
        if (esc_r == ESC_HEX) begin
          rb[rn] = held_char(hexd_r, hexup_r);
          rn     = rn + NRES_W'(1);
        end
      end
      phase_nxt = PH_BEFORE_Q;
      kpos_nxt  = '0;
      kmis_nxt  = 1'b0;
      esc_nxt   = ESC_NONE;
      hexd_nxt  = '0;
      hexup_nxt = 1'b0;
      vcnt_nxt  = '0;
    end else begin
      case (phase_r)
        PH_BEFORE_Q: begin
          if (c == CH_QMARK) begin
            phase_nxt = PH_NAME;
            kpos_nxt  = '0;
            kmis_nxt  = 1'b0;
          end
        end
        PH_NAME: begin
          if (c == CH_AMP) begin
            kpos_nxt = '0;
            kmis_nxt = 1'b0;
          end else if (c == CH_EQ) begin
            if (!kmis_r && kpos_r == klen_eff) begin
              phase_nxt = PH_VALUE;
              vcnt_nxt  = '0;
              esc_nxt   = ESC_NONE;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end else if (!kmis_r && kpos_r < klen_eff && c == kchar) begin
            kpos_nxt = kpos_r + KLEN_W'(1);
          end else begin
            kmis_nxt = 1'b1;
          end
        end
        PH_SKIP: begin
          if (c == CH_AMP) begin
            phase_nxt = PH_NAME;
            kpos_nxt  = '0;
            kmis_nxt  = 1'b0;
          end
        end
        PH_VALUE: begin
          if (c == CH_AMP || vcnt_r >= VCNT_W'(VALUE_LIMIT - 1)) begin
            // value ends, pending escape goes out literally
            if (esc_r != ESC_NONE) begin
              rb[rn] = CH_PCT;
              rn     = rn + NRES_W'(1);
            end
            if (esc_r == ESC_HEX) begin
              rb[rn] = held_char(hexd_r, hexup_r);
              rn     = rn + NRES_W'(1);
            end
            esc_nxt   = ESC_NONE;
            phase_nxt = PH_DONE;
          end else begin
            vcnt_nxt = vcnt_r + VCNT_W'(1);
            if (esc_r == ESC_PCT && c_hex) begin
              hexd_nxt  = hex_val(c);
              hexup_nxt = (c inside {[8'h41:8'h46]});
              esc_nxt   = ESC_HEX;
            end else if (esc_r == ESC_HEX && c_hex) begin
              rb[rn]  = {hexd_r, hex_val(c)};
              rn      = rn + NRES_W'(1);
              esc_nxt = ESC_NONE;
            end else begin
              if (esc_r != ESC_NONE) begin
                rb[rn] = CH_PCT;
                rn     = rn + NRES_W'(1);
              end
              if (esc_r == ESC_HEX) begin
                rb[rn] = held_char(hexd_r, hexup_r);
                rn     = rn + NRES_W'(1);
              end
              esc_nxt = ESC_NONE;
              if (c == CH_PCT) begin
                esc_nxt = ESC_PCT;
              end else if (c == CH_PLUS) begin
                rb[rn] = CH_SPACE;
                rn     = rn + NRES_W'(1);
              end else begin
                rb[rn] = c;
                rn     = rn + NRES_W'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output buffer limit: kept bytes are always a prefix of the raw list
  always_comb begin
    keep = '0;
    if (cap_ok && rn >= NRES_W'(1) && ecnt_ext < limit) begin
      keep = NRES_W'(1);
    end
    if (cap_ok && rn >= NRES_W'(2) && (ecnt_ext + CAP_W'(1)) < limit) begin
      keep = NRES_W'(2);
    end
    if (cap_ok && rn >= NRES_W'(3) && (ecnt_ext + CAP_W'(2)) < limit) begin
      keep = NRES_W'(3);
    end
    if (in_chan.end_of_url) begin
      ecnt_nxt = '0;
    end else begin
      ecnt_nxt = ecnt_r + ECNT_W'(keep);
    end
  end

  always_comb begin
    q_cmd.bytes  = rb;
    q_cmd.status = in_chan.end_of_url;
    q_cmd.found  = (phase_r == PH_VALUE || phase_r == PH_DONE) && cap_ok;
    q_cmd.nres   = in_chan.end_of_url ? keep + NRES_W'(1) : keep;
    q_push       = accept && (in_chan.end_of_url || keep != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BEFORE_Q;
      kpos_r  <= '0;
      kmis_r  <= 1'b0;
      esc_r   <= ESC_NONE;
      hexd_r  <= '0;
      hexup_r <= 1'b0;
      ecnt_r  <= '0;
      vcnt_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      kpos_r  <= kpos_nxt;
      kmis_r  <= kmis_nxt;
      esc_r   <= esc_nxt;
      hexd_r  <= hexd_nxt;
      hexup_r <= hexup_nxt;
      ecnt_r  <= ecnt_nxt;
      vcnt_r  <= vcnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uqpd_queue.sv =====
`default_nettype none

module uqpd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire uqpd_pkg::uqpd_cmd_t push_cmd,
  input  wire logic          pop,
  output uqpd_pkg::uqpd_cmd_t head_cmd,
  output logic               full,
  output logic               empty
);
  import uqpd_pkg::*;

  uqpd_cmd_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = cnt_r == QCNT_W'(QDEPTH);
  assign empty    = cnt_r == '0;
  assign head_cmd = mem_r[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_nxt  = do_push ? QPTR_W'(wr_r + QPTR_W'(1)) : wr_r;
    rd_nxt  = do_pop ? QPTR_W'(rd_r + QPTR_W'(1)) : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/uqpd_back.sv =====
`default_nettype none

module uqpd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire uqpd_pkg::uqpd_cmd_t head_cmd,
  input  wire logic          q_empty,
  output logic               q_pop,
  uqpd_out_if.source         out_chan
);
  import uqpd_pkg::*;

  uqpd_cmd_t         cur_r;
  logic              cur_vld_r;
  logic [NRES_W-1:0] idx_r;
  logic              out_vld_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              found_r;
  logic              done_r;

  logic              advance;
  logic              last;
  logic              is_status;

  assign advance   = cur_vld_r && (!out_vld_r || out_chan.ready);
  assign last      = idx_r == (cur_r.nres - NRES_W'(1));
  assign is_status = cur_r.status && last;
  assign q_pop     = (!cur_vld_r || (advance && last)) && !q_empty;

  assign out_chan.valid    = out_vld_r;
  assign out_chan.out_char = out_char_r;
  assign out_chan.found    = found_r;
  assign out_chan.done_res = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_vld_r <= 1'b1;
        idx_r     <= '0;
      end else if (advance && last) begin
        cur_vld_r <= 1'b0;
      end else if (advance) begin
        idx_r <= idx_r + NRES_W'(1);
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= head_cmd;
    end
    if (advance) begin
      out_char_r <= is_status ? '0 : cur_r.bytes[idx_r];
      found_r    <= is_status && cur_r.found;
      done_r     <= is_status;
    end
  end

endmodule

`default_nettype wire
